/* rtl/core/sts_pkg.sv */
// ----------------------------------------------------------------------------
// Script token scanner package
// Shared constants for the scanner: token kinds, fault codes, byte codes and
// the keyword table with its lookup function.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int POSITION_BITS_DEF = 24;
   localparam int KEYWORD_BYTES     = 8;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int KEYWORD_COUNT     = 23;

   localparam logic [5:0] K_EOF     = 6'd0;
   localparam logic [5:0] K_INT     = 6'd1;
   localparam logic [5:0] K_FLOAT   = 6'd2;
   localparam logic [5:0] K_IDENT   = 6'd3;
   localparam logic [5:0] K_SBYTE   = 6'd4;
   localparam logic [5:0] K_SEND    = 6'd5;
   localparam logic [5:0] K_KW0     = 6'd6;
   localparam logic [5:0] K_NE      = 6'd29;
   localparam logic [5:0] K_EE      = 6'd30;
   localparam logic [5:0] K_EQ      = 6'd31;
   localparam logic [5:0] K_LTE     = 6'd32;
   localparam logic [5:0] K_LT      = 6'd33;
   localparam logic [5:0] K_GTE     = 6'd34;
   localparam logic [5:0] K_GT      = 6'd35;
   localparam logic [5:0] K_PLUS    = 6'd36;
   localparam logic [5:0] K_MINUS   = 6'd37;
   localparam logic [5:0] K_LBRACK  = 6'd38;
   localparam logic [5:0] K_RBRACK  = 6'd39;
   localparam logic [5:0] K_LBRACE  = 6'd40;
   localparam logic [5:0] K_RBRACE  = 6'd41;
   localparam logic [5:0] K_COLON   = 6'd42;
   localparam logic [5:0] K_COMMA   = 6'd43;
   localparam logic [5:0] K_STAR    = 6'd44;
   localparam logic [5:0] K_SLASH   = 6'd45;
   localparam logic [5:0] K_CARET   = 6'd46;
   localparam logic [5:0] K_LPAREN  = 6'd47;
   localparam logic [5:0] K_RPAREN  = 6'd48;
   localparam logic [5:0] K_DOT     = 6'd49;
   localparam logic [5:0] K_INVALID = 6'd50;

   localparam logic [2:0] F_NONE     = 3'd0;
   localparam logic [2:0] F_RANGE    = 3'd1;
   localparam logic [2:0] F_UNTERM   = 3'd2;
   localparam logic [2:0] F_ESCAPE   = 3'd3;
   localparam logic [2:0] F_CHCOUNT  = 3'd4;
   localparam logic [2:0] F_NONASCII = 3'd5;
   localparam logic [2:0] F_BANG     = 3'd6;
   localparam logic [2:0] F_ILLEGAL  = 3'd7;

   localparam logic [62:0] VALUE_MAX = {63{1'b1}};
   localparam logic [63:0] CASE_FOLD = 64'hDFDF_DFDF_DFDF_DFDF;
   localparam logic [7:0]  ASCII_MAX = 8'h7F;

   localparam logic [7:0] B_NUL    = 8'h00;
   localparam logic [7:0] B_TAB    = 8'h09;
   localparam logic [7:0] B_LF     = 8'h0A;
   localparam logic [7:0] B_CR     = 8'h0D;
   localparam logic [7:0] B_SPACE  = 8'h20;
   localparam logic [7:0] B_BANG   = 8'h21;
   localparam logic [7:0] B_DQUOTE = 8'h22;
   localparam logic [7:0] B_HASH   = 8'h23;
   localparam logic [7:0] B_SQUOTE = 8'h27;
   localparam logic [7:0] B_DOT    = 8'h2E;
   localparam logic [7:0] B_ZERO   = 8'h30;
   localparam logic [7:0] B_LT     = 8'h3C;
   localparam logic [7:0] B_EQ     = 8'h3D;
   localparam logic [7:0] B_GT     = 8'h3E;
   localparam logic [7:0] B_BSLASH = 8'h5C;
   localparam logic [7:0] B_UNDER  = 8'h5F;
   localparam logic [7:0] B_LOW_N  = 8'h6E;
   localparam logic [7:0] B_LOW_R  = 8'h72;
   localparam logic [7:0] B_LOW_T  = 8'h74;

   // Keyword spellings, first byte in the low byte.
   localparam logic [63:0] KW_WORD [KEYWORD_COUNT] = '{
      64'h4649, 64'h4E46, 64'h524F, 64'h4E49, 64'h444E41, 64'h444E45,
      64'h595254, 64'h524156, 64'h524F46, 64'h544F4E, 64'h46494C45,
      64'h45534C45, 64'h4E454854, 64'h4C4C554E, 64'h45555254,
      64'h4B41455242, 64'h454C494857, 64'h4843544143, 64'h5353414C43,
      64'h45534C4146, 64'h54524F504D49, 64'h4E5255544552,
      64'h45554E49544E4F43
   };
   localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
      4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
      4'd6, 4'd6, 4'd8
   };

   // Kind of a finished identifier: a keyword when the folded word and the
   // length both match, a plain identifier otherwise.
   function automatic logic [5:0] keyword_kind(input logic [63:0] word,
                                               input logic [3:0] len);
      logic [5:0]  kind;
      logic [63:0] folded;
      kind   = K_IDENT;
      folded = word & CASE_FOLD;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         if (len == KW_LEN[i] && folded == KW_WORD[i]) begin
            kind = K_KW0 + 6'(i);
         end
      end
      return kind;
   endfunction

endpackage

/* rtl/core/sts_front.sv */
// ----------------------------------------------------------------------------
// Scanner front end
// Takes one text byte per accepted item, runs the lexer state machine and
// produces a bundle of up to three result records for that byte.
// ----------------------------------------------------------------------------
module sts_front #(
   parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF,
   parameter int REC_W         = 72 + 4 * POSITION_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_fire,
   input  logic [7:0]         text_byte,
   output logic [1:0]         bundle_count,
   output logic [3*REC_W-1:0] bundle_recs
);
   import sts_pkg::*;

   localparam int PB = POSITION_BITS;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_NUM, M_STR, M_STR_ESC, M_CH_OPEN, M_CH_ESC,
      M_CH_CLOSE, M_BANG, M_EQ, M_LT, M_GT, M_COMMENT
   } mode_type;

   typedef struct packed {
      logic [5:0]    kind;
      logic [62:0]   value;
      logic [PB-1:0] span_start;
      logic [PB-1:0] span_end;
      logic [PB-1:0] line;
      logic [PB-1:0] column;
      logic [2:0]    fault;
   } rec_type;

   mode_type      mode_ff, mode_in;
   logic [63:0]   word_ff, word_in;
   logic [3:0]    len_ff, len_in;
   logic [62:0]   acc_ff, acc_in;
   logic          ovf_ff, ovf_in;
   logic          dot_ff, dot_in;
   logic [6:0]    chr_ff, chr_in;
   logic [PB-1:0] cur_ff, cur_in;
   logic [PB-1:0] line_ff, line_in;
   logic [PB-1:0] col_ff, col_in;
   logic [PB-1:0] org_ff, org_in;
   logic [PB-1:0] oline_ff, oline_in;
   logic [PB-1:0] ocol_ff, ocol_in;

   rec_type       recs [3];
   logic [1:0]    count;

   function automatic rec_type mk(input logic [5:0] k, input logic [62:0] v,
                                  input logic [PB-1:0] s, input logic [PB-1:0] e,
                                  input logic [PB-1:0] l, input logic [PB-1:0] c,
                                  input logic [2:0] f);
      rec_type r;
      r.kind = k; r.value = v; r.span_start = s; r.span_end = e;
      r.line = l; r.column = c; r.fault = f;
      return r;
   endfunction

   always_comb begin
      logic          reex;
      logic          is_letter;
      logic          is_digit;
      logic [PB-1:0] here;
      logic [PB-1:0] nxt;
      logic [66:0]   prod;
      logic [7:0]    esc;
      logic [5:0]    op_kind;
      logic          op_hit;

      mode_in  = mode_ff;  word_in  = word_ff;  len_in = len_ff;
      acc_in   = acc_ff;   ovf_in   = ovf_ff;   dot_in = dot_ff;
      chr_in   = chr_ff;   org_in   = org_ff;   oline_in = oline_ff;
      ocol_in  = ocol_ff;
      recs     = '{default: '0};
      count    = 2'd0;
      reex     = 1'b0;
      here     = cur_ff;
      nxt      = cur_ff + 1'b1;
      is_letter = (text_byte >= 8'h61 && text_byte <= 8'h7A) ||
                  (text_byte >= 8'h41 && text_byte <= 8'h5A);
      is_digit  = text_byte >= B_ZERO && text_byte <= 8'h39;
      // Ten times the accumulator plus the digit, from shifts and adds.
      prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
             {63'b0, text_byte[3:0]};
      priority if (text_byte == B_LOW_N) esc = B_LF;
      else if (text_byte == B_LOW_T)     esc = B_TAB;
      else if (text_byte == B_LOW_R)     esc = B_CR;
      else if (text_byte == B_ZERO)      esc = B_NUL;
      else                               esc = text_byte;
      op_hit = 1'b1;
      unique case (text_byte)
         8'h2B:   op_kind = K_PLUS;
         8'h2D:   op_kind = K_MINUS;
         8'h5B:   op_kind = K_LBRACK;
         8'h5D:   op_kind = K_RBRACK;
         8'h7B:   op_kind = K_LBRACE;
         8'h7D:   op_kind = K_RBRACE;
         8'h3A:   op_kind = K_COLON;
         8'h2C:   op_kind = K_COMMA;
         8'h2A:   op_kind = K_STAR;
         8'h2F:   op_kind = K_SLASH;
         8'h5E:   op_kind = K_CARET;
         8'h28:   op_kind = K_LPAREN;
         8'h29:   op_kind = K_RPAREN;
         B_DOT:   op_kind = K_DOT;
         default: begin
            op_kind = K_INVALID;
            op_hit  = 1'b0;
         end
      endcase

      // Bytes inside a pending token.
      if (mode_ff == M_IDLE) begin
         reex = 1'b1;
      end else begin
         mode_in = M_IDLE;
         unique case (mode_ff)
            M_IDENT: begin
               if (is_letter || is_digit || text_byte == B_UNDER) begin
                  if (len_ff < 4'(KEYWORD_BYTES)) begin
                     word_in[8*len_ff[2:0] +: 8] = text_byte;
                  end
                  if (len_ff < 4'd9) len_in = len_ff + 4'd1;
                  mode_in = M_IDENT;
               end else begin
                  recs[count] = mk(keyword_kind(word_ff, len_ff), '0, org_ff, here,
                                   oline_ff, ocol_ff, F_NONE);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end
            end
            M_NUM: begin
               if (is_digit) begin
                  if (!dot_ff && !ovf_ff) begin
                     if (prod > {4'b0, VALUE_MAX}) ovf_in = 1'b1;
                     else acc_in = prod[62:0];
                  end
                  mode_in = M_NUM;
               end else if (text_byte == B_DOT && !dot_ff) begin
                  dot_in  = 1'b1;
                  mode_in = M_NUM;
               end else begin
                  priority if (dot_ff)
                     recs[count] = mk(K_FLOAT, '0, org_ff, here, oline_ff, ocol_ff,
                                      F_NONE);
                  else if (ovf_ff)
                     recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                      F_RANGE);
                  else
                     recs[count] = mk(K_INT, acc_ff, org_ff, here, oline_ff, ocol_ff,
                                      F_NONE);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end
            end
            M_STR: begin
               priority if (text_byte == B_NUL) begin
                  recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                   F_UNTERM);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end else if (text_byte == B_DQUOTE) begin
                  recs[count] = mk(K_SEND, '0, org_ff, nxt, oline_ff, ocol_ff, F_NONE);
                  count = count + 2'd1;
               end else if (text_byte == B_BSLASH) begin
                  mode_in = M_STR_ESC;
               end else begin
                  recs[count] = mk(K_SBYTE, {55'b0, text_byte}, org_ff, nxt,
                                   oline_ff, ocol_ff, F_NONE);
                  count   = count + 2'd1;
                  mode_in = M_STR;
               end
            end
            M_STR_ESC: begin
               recs[count] = mk(K_SBYTE, {55'b0, esc}, org_ff, nxt, oline_ff, ocol_ff,
                                F_NONE);
               count = count + 2'd1;
               if (text_byte == B_NUL) begin
                  recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                   F_UNTERM);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end else begin
                  mode_in = M_STR;
               end
            end
            M_CH_OPEN: begin
               priority if (text_byte == B_BSLASH) begin
                  mode_in = M_CH_ESC;
               end else if (text_byte == B_SQUOTE || text_byte == B_NUL) begin
                  recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                   F_CHCOUNT);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end else if (text_byte > ASCII_MAX) begin
                  recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                   F_NONASCII);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end else begin
                  chr_in  = text_byte[6:0];
                  mode_in = M_CH_CLOSE;
               end
            end
            M_CH_ESC: begin
               if (text_byte == B_LOW_N || text_byte == B_LOW_T ||
                   text_byte == B_LOW_R || text_byte == B_ZERO ||
                   text_byte == B_BSLASH || text_byte == B_SQUOTE ||
                   text_byte == B_DQUOTE) begin
                  chr_in  = esc[6:0];
                  mode_in = M_CH_CLOSE;
               end else begin
                  recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                   F_ESCAPE);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end
            end
            M_CH_CLOSE: begin
               if (text_byte == B_SQUOTE) begin
                  recs[count] = mk(K_INT, {56'b0, chr_ff}, org_ff, nxt, oline_ff,
                                   ocol_ff, F_NONE);
                  count = count + 2'd1;
               end else begin
                  recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                   F_CHCOUNT);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end
            end
            M_BANG: begin
               if (text_byte == B_EQ) begin
                  recs[count] = mk(K_NE, '0, org_ff, nxt, oline_ff, ocol_ff, F_NONE);
                  count = count + 2'd1;
               end else begin
                  recs[count] = mk(K_INVALID, '0, org_ff, here, oline_ff, ocol_ff,
                                   F_BANG);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end
            end
            M_EQ, M_LT, M_GT: begin
               if (text_byte == B_EQ) begin
                  recs[count] = mk((mode_ff == M_EQ) ? K_EE :
                                   (mode_ff == M_LT) ? K_LTE : K_GTE,
                                   '0, org_ff, nxt, oline_ff, ocol_ff, F_NONE);
                  count = count + 2'd1;
               end else begin
                  recs[count] = mk((mode_ff == M_EQ) ? K_EQ :
                                   (mode_ff == M_LT) ? K_LT : K_GT,
                                   '0, org_ff, here, oline_ff, ocol_ff, F_NONE);
                  count = count + 2'd1;
                  reex  = 1'b1;
               end
            end
            M_COMMENT: begin
               if (text_byte == B_LF || text_byte == B_NUL) reex = 1'b1;
               else mode_in = M_COMMENT;
            end
            default: reex = 1'b1;
         endcase
      end

      // The byte seen from the idle state.
      if (reex) begin
         priority if (text_byte == B_SPACE || text_byte == B_TAB ||
                      text_byte == B_LF) begin
            mode_in = M_IDLE;
         end else if (text_byte == B_NUL) begin
            recs[count] = mk(K_EOF, '0, here, here, line_ff, col_ff, F_NONE);
            count = count + 2'd1;
         end else if (text_byte == B_HASH) begin
            mode_in = M_COMMENT;
         end else if (op_hit) begin
            recs[count] = mk(op_kind, '0, here, nxt, line_ff, col_ff, F_NONE);
            count = count + 2'd1;
         end else if (text_byte == B_DQUOTE || text_byte == B_SQUOTE ||
                      text_byte == B_BANG || text_byte == B_EQ ||
                      text_byte == B_LT || text_byte == B_GT || is_digit ||
                      is_letter || text_byte == B_UNDER) begin
            org_in   = cur_ff;
            oline_in = line_ff;
            ocol_in  = col_ff;
            word_in  = '0;
            len_in   = '0;
            acc_in   = '0;
            ovf_in   = 1'b0;
            dot_in   = 1'b0;
            chr_in   = '0;
            priority if (text_byte == B_DQUOTE) mode_in = M_STR;
            else if (text_byte == B_SQUOTE)     mode_in = M_CH_OPEN;
            else if (text_byte == B_BANG)       mode_in = M_BANG;
            else if (text_byte == B_EQ)         mode_in = M_EQ;
            else if (text_byte == B_LT)         mode_in = M_LT;
            else if (text_byte == B_GT)         mode_in = M_GT;
            else if (is_digit) begin
               mode_in = M_NUM;
               acc_in  = {59'b0, text_byte[3:0]};
            end else begin
               mode_in = M_IDENT;
               word_in = {56'b0, text_byte};
               len_in  = 4'd1;
            end
         end else begin
            recs[count] = mk(K_INVALID, '0, here, nxt, line_ff, col_ff, F_ILLEGAL);
            count = count + 2'd1;
         end
      end

      // End of text returns everything to the reset state.
      if (text_byte == B_NUL) begin
         mode_in = M_IDLE; word_in = '0; len_in = '0; acc_in = '0;
         ovf_in = 1'b0; dot_in = 1'b0; chr_in = '0;
         cur_in = '0; line_in = '0; col_in = '0;
         org_in = '0; oline_in = '0; ocol_in = '0;
      end else begin
         cur_in = nxt;
         if (text_byte == B_LF) begin
            line_in = line_ff + 1'b1;
            col_in  = '0;
         end else begin
            line_in = line_ff;
            col_in  = col_ff + 1'b1;
         end
      end
   end

   assign bundle_count = count;
   assign bundle_recs  = {recs[2], recs[1], recs[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; word_ff <= '0; len_ff <= '0; acc_ff <= '0;
         ovf_ff <= 1'b0; dot_ff <= 1'b0; chr_ff <= '0;
         cur_ff <= '0; line_ff <= '0; col_ff <= '0;
         org_ff <= '0; oline_ff <= '0; ocol_ff <= '0;
      end else if (in_fire) begin
         mode_ff <= mode_in; word_ff <= word_in; len_ff <= len_in;
         acc_ff <= acc_in; ovf_ff <= ovf_in; dot_ff <= dot_in; chr_ff <= chr_in;
         cur_ff <= cur_in; line_ff <= line_in; col_ff <= col_in;
         org_ff <= org_in; oline_ff <= oline_in; ocol_ff <= ocol_in;
      end
   end

endmodule

/* rtl/core/sts_queue.sv */
// ----------------------------------------------------------------------------
// Scanner bundle queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sts_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign empty     = (cnt_ff == '0);
   assign full      = (cnt_ff == CW'(DEPTH));
   assign head_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

/* rtl/core/sts_back.sv */
// ----------------------------------------------------------------------------
// Scanner back end
// Unpacks one bundle at a time into single results and holds each one in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sts_back #(
   parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF,
   parameter int REC_W         = 72 + 4 * POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  logic [1:0]               head_count,
   input  logic [3*REC_W-1:0]       head_recs,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [5:0]               rsp_token_kind,
   output logic [62:0]              rsp_token_value,
   output logic [POSITION_BITS-1:0] rsp_span_start,
   output logic [POSITION_BITS-1:0] rsp_span_end,
   output logic [POSITION_BITS-1:0] rsp_start_line,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic [2:0]               rsp_fault_code,
   output logic                     rsp_run_last
);
   localparam int PB = POSITION_BITS;

   typedef struct packed {
      logic [5:0]    kind;
      logic [62:0]   value;
      logic [PB-1:0] span_start;
      logic [PB-1:0] span_end;
      logic [PB-1:0] line;
      logic [PB-1:0] column;
      logic [2:0]    fault;
   } rec_type;

   logic       valid_ff, valid_in;
   logic [1:0] sub_ff, sub_in;
   logic       load;
   logic       last;
   rec_type    pick;
   rec_type    out_ff;
   logic       last_ff;

   assign load = head_valid && (!valid_ff || rsp_ready);
   assign last = (sub_ff == head_count - 2'd1);
   assign pop  = load && last;
   assign pick = rec_type'(head_recs[REC_W*sub_ff +: REC_W]);

   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = last ? 2'd0 : sub_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
      if (load) begin
         out_ff  <= pick;
         last_ff <= last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = out_ff.kind;
   assign rsp_token_value  = out_ff.value;
   assign rsp_span_start   = out_ff.span_start;
   assign rsp_span_end     = out_ff.span_end;
   assign rsp_start_line   = out_ff.line;
   assign rsp_start_column = out_ff.column;
   assign rsp_fault_code   = out_ff.fault;
   assign rsp_run_last     = last_ff;

endmodule

/* rtl/core/script_token_scanner_top.sv */
// ----------------------------------------------------------------------------
// Script token scanner
// Streaming lexer: source bytes in, tokens with spans and positions out.
// ----------------------------------------------------------------------------
// Usage: source text enters one byte per item on the req_ channel; a zero
// byte ends the text, flushes any pending token, emits an EOF token and
// returns the scanner to its reset state. Each byte yields zero to three
// result items on the rsp_ channel; rsp_run_last marks the last item
// caused by a given byte.
// Throughput: one byte is accepted every cycle while the bundle queue has
// room. The result side delivers one item per cycle while rsp_ready is
// high, so a byte that causes several items holds the output once per item.
// Path: a byte's bundle is written into the queue at the edge that
// accepts the byte; its first result is then loaded from the queue head
// into the output register, which drives rsp_valid, as soon as that
// register is empty or its item is being taken by the receiver.
// Reset: synchronous and active high; it clears the scanner state, the
// queue pointers and the output valid flag. No clearing pass is needed.
// Stalls: when rsp_ready is low the output register holds its item, the
// queue fills, and req_ready drops once it is full; the front end keeps
// scanning until then.
// ----------------------------------------------------------------------------
module script_token_scanner_top #(
   parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF,
   parameter int QUEUE_DEPTH   = sts_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_text_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [5:0]               rsp_token_kind,
   output logic [62:0]              rsp_token_value,
   output logic [POSITION_BITS-1:0] rsp_span_start,
   output logic [POSITION_BITS-1:0] rsp_span_end,
   output logic [POSITION_BITS-1:0] rsp_start_line,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic [2:0]               rsp_fault_code,
   output logic                     rsp_run_last
);
   import sts_pkg::*;

   // One result record: kind, value, fault and four position fields.
   localparam int REC_W = 72 + 4 * POSITION_BITS;
   localparam int BUNDLE_W = 2 + 3 * REC_W;

   logic                in_fire;
   logic [1:0]          f_count;
   logic [3*REC_W-1:0]  f_recs;
   logic                q_push;
   logic                q_pop;
   logic                q_empty;
   logic                q_full;
   logic [BUNDLE_W-1:0] q_head;

   // A byte is taken whenever the queue has a free slot, even while the
   // output register still waits for the receiver.
   assign req_ready = !q_full;
   assign in_fire   = req_valid && req_ready;
   // Bytes that produce no result (blanks, comment text, token bodies)
   // never occupy a queue slot.
   assign q_push    = in_fire && (f_count != 2'd0);

   sts_front #(
      .POSITION_BITS(POSITION_BITS),
      .REC_W(REC_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .text_byte   (req_text_byte),
      .bundle_count(f_count),
      .bundle_recs (f_recs)
   );

   sts_queue #(
      .WIDTH(BUNDLE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data({f_count, f_recs}),
      .pop      (q_pop),
      .head_data(q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   sts_back #(
      .POSITION_BITS(POSITION_BITS),
      .REC_W(REC_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (!q_empty),
      .head_count      (q_head[BUNDLE_W-1 -: 2]),
      .head_recs       (q_head[3*REC_W-1:0]),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_value (rsp_token_value),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_end    (rsp_span_end),
      .rsp_start_line  (rsp_start_line),
      .rsp_start_column(rsp_start_column),
      .rsp_fault_code  (rsp_fault_code),
      .rsp_run_last    (rsp_run_last)
   );

   // The queue can never be both full and empty.
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("bundle queue reports full and empty together");

   // A fault code only accompanies an INVALID token.
   a_fault_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fault_code != F_NONE) |-> rsp_token_kind == K_INVALID)
      else $error("fault code on a token that is not INVALID");

   // EOF is always the final item caused by its byte.
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == K_EOF) |-> rsp_run_last)
      else $error("EOF item not marked as last of its byte");

   // Nothing is popped from an empty queue.
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule
